FILE: sv/abms_pkg.sv
// shared types and codes for the adjacency bit-matrix store
package abms_pkg;

  // command codes as seen on the input channel
  localparam logic [2:0] CMD_TOGGLE  = 3'd0;
  localparam logic [2:0] CMD_ADD     = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_QUERY   = 3'd3;
  localparam logic [2:0] CMD_COUNT   = 3'd4;
  localparam logic [2:0] CMD_PARTNER = 3'd5;

  // update flavour, taken from the low command bits
  localparam logic [1:0] UPD_TOGGLE = 2'd0;
  localparam logic [1:0] UPD_ADD    = 2'd1;

  // partner kinds: out-out, out-in, in-in, in-out
  localparam logic [1:0] KIND_OSP = 2'd0;
  localparam logic [1:0] KIND_OTP = 2'd1;
  localparam logic [1:0] KIND_ISP = 2'd2;
  localparam logic [1:0] KIND_ITP = 2'd3;

  // configuration register indexes
  localparam logic CFG_DIRECTED = 1'b0;
  localparam logic CFG_ACTORS   = 1'b1;

  localparam logic [6:0] ACTORS_RST = 7'd64;

  typedef enum logic [2:0] {
    OP_UPDATE,
    OP_QUERY,
    OP_COUNT,
    OP_PARTNER,
    OP_NOP,
    OP_BADID
  } op_t;

  // one classified item between front and back
  typedef struct packed {
    op_t        op;
    logic [1:0] sub;
    logic [6:0] a;
    logic [6:0] b;
  } job_t;

  typedef struct packed {
    logic        valid;
    logic        status;
    logic        edge_value;
    logic [12:0] edge_total;
    logic [6:0]  partner_id;
    logic        partner_valid;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIMPLE,
    ST_RD1,
    ST_UPD,
    ST_QRY,
    ST_PA,
    ST_PB,
    ST_SCAN,
    ST_FLUSH
  } st_t;

endpackage

FILE: sv/abms_front.sv
// front end: configuration registers, range check and item classification
module abms_front #(
  parameter int unsigned MAX_ACTORS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [2:0]       in_cmd,
  input  logic [6:0]       in_from_actor,
  input  logic [6:0]       in_to_actor,
  input  logic [1:0]       in_partner_kind,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [6:0]       cfg_wdata,
  input  logic             q_full,
  output logic             busy,
  output logic             q_push,
  output abms_pkg::job_t   q_job,
  output logic             directed
);
  import abms_pkg::*;

  localparam int unsigned CAP = (MAX_ACTORS > 127) ? 127 : MAX_ACTORS;
  localparam logic [6:0] CAP7 = 7'(CAP);

  logic       directed_r;
  logic [6:0] actor_count_r;
  logic [6:0] n_eff;
  logic       ids_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      directed_r    <= 1'b1;
      actor_count_r <= ACTORS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTED: directed_r    <= cfg_wdata[0];
        CFG_ACTORS:   actor_count_r <= cfg_wdata;
      endcase
    end
  end

  assign n_eff  = (actor_count_r > CAP7) ? CAP7 : actor_count_r;
  assign ids_ok = (in_from_actor != 7'd0) && (in_from_actor <= n_eff) &&
                  (in_to_actor != 7'd0) && (in_to_actor <= n_eff);

  always_comb begin
    q_job.a = in_from_actor - 7'd1;
    q_job.b = in_to_actor - 7'd1;
    q_job.sub = (in_cmd == CMD_PARTNER) ? in_partner_kind : in_cmd[1:0];
    priority if (in_cmd == CMD_COUNT) begin
      q_job.op = OP_COUNT;
    end else if (in_cmd > CMD_PARTNER) begin
      q_job.op = OP_NOP;
    end else if (!ids_ok) begin
      q_job.op = OP_BADID;
    end else if (in_cmd <= CMD_DELETE) begin
      q_job.op = OP_UPDATE;
    end else if (in_cmd == CMD_QUERY) begin
      q_job.op = OP_QUERY;
    end else begin
      q_job.op = OP_PARTNER;
    end
  end

  assign busy     = q_full;
  assign q_push   = start & ~q_full;
  assign directed = directed_r;

endmodule

FILE: sv/abms_queue.sv
// two-entry item queue between front and back
module abms_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  abms_pkg::job_t push_job,
  input  logic           pop,
  output abms_pkg::job_t head,
  output logic           full,
  output logic           empty
);
  import abms_pkg::*;

  job_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head  = ent_r[rd_ptr_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule

FILE: sv/abms_back.sv
// back end: row memories, edge counter and the command sequencer
module abms_back #(
  parameter int unsigned MAX_ACTORS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           directed,
  input  logic           q_empty,
  input  abms_pkg::job_t q_head,
  output logic           q_pop,
  output abms_pkg::res_t res
);
  import abms_pkg::*;

  localparam int unsigned AW = (MAX_ACTORS > 1) ? $clog2(MAX_ACTORS) : 1;
  localparam logic [AW-1:0] IDX_LAST = AW'(MAX_ACTORS - 1);

  logic [MAX_ACTORS-1:0] out_mem [MAX_ACTORS];
  logic [MAX_ACTORS-1:0] in_mem  [MAX_ACTORS];
  logic [MAX_ACTORS-1:0] out_q_r, in_q_r;
  logic                  out_rv_r, in_rv_r;
  logic [MAX_ACTORS-1:0] out_vld_r, in_vld_r;

  st_t                   state_r, state_nxt;
  job_t                  job_r;
  logic                  second_r, second_nxt;
  logic                  v_r, v_nxt;
  logic [MAX_ACTORS-1:0] sa_r, sa_nxt;
  logic [MAX_ACTORS-1:0] mask_r, mask_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  have_r, have_nxt;
  logic [6:0]            pend_r, pend_nxt;
  logic [12:0]           cnt_r, cnt_nxt;
  res_t                  res_r, res_nxt;

  logic [AW-1:0]         xa, xb, x, y;
  logic [AW-1:0]         out_raddr, in_raddr;
  logic [MAX_ACTORS-1:0] orow, irow;
  logic                  cur, v_new;
  logic                  out_we, in_we;
  logic [MAX_ACTORS-1:0] out_wdata, in_wdata;

  assign xa = AW'(job_r.a);
  assign xb = AW'(job_r.b);
  // second pass of an undirected update works on the mirrored edge
  assign x  = second_r ? xb : xa;
  assign y  = second_r ? xa : xb;

  assign orow = out_rv_r ? out_q_r : '0;
  assign irow = in_rv_r ? in_q_r : '0;
  assign cur  = orow[y];

  always_comb begin
    if (second_r) begin
      v_new = v_r;
    end else if (job_r.sub == UPD_TOGGLE) begin
      v_new = ~cur;
    end else begin
      v_new = (job_r.sub == UPD_ADD);
    end
  end

  // memories: one write and one registered read per array per cycle
  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[x] <= out_wdata;
    end
    if (in_we) begin
      in_mem[y] <= in_wdata;
    end
    out_q_r <= out_mem[out_raddr];
    in_q_r  <= in_mem[in_raddr];
  end

  // rows never written read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= '0;
      in_vld_r  <= '0;
      out_rv_r  <= 1'b0;
      in_rv_r   <= 1'b0;
    end else begin
      if (out_we) begin
        out_vld_r[x] <= 1'b1;
      end
      if (in_we) begin
        in_vld_r[y] <= 1'b1;
      end
      out_rv_r <= out_vld_r[out_raddr];
      in_rv_r  <= in_vld_r[in_raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.op)
            OP_UPDATE, OP_QUERY, OP_PARTNER: state_nxt = ST_RD1;
            default:                         state_nxt = ST_SIMPLE;
          endcase
        end
      end
      ST_SIMPLE: state_nxt = ST_IDLE;
      ST_RD1: begin
        unique case (job_r.op)
          OP_UPDATE: state_nxt = ST_UPD;
          OP_QUERY:  state_nxt = ST_QRY;
          default:   state_nxt = ST_PA;
        endcase
      end
      ST_UPD:   state_nxt = (directed || second_r) ? ST_IDLE : ST_RD1;
      ST_QRY:   state_nxt = ST_IDLE;
      ST_PA:    state_nxt = ST_PB;
      ST_PB:    state_nxt = ST_SCAN;
      ST_SCAN:  state_nxt = (idx_r == IDX_LAST) ? ST_FLUSH : ST_SCAN;
      ST_FLUSH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    second_nxt = second_r;
    v_nxt      = v_r;
    sa_nxt     = sa_r;
    mask_nxt   = mask_r;
    idx_nxt    = idx_r;
    have_nxt   = have_r;
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    res_nxt    = '0;
    out_we     = 1'b0;
    in_we      = 1'b0;
    out_wdata  = orow;
    in_wdata   = irow;
    out_wdata[y] = v_new;
    in_wdata[x]  = v_new;
    out_raddr  = (state_r == ST_PA) ? xb : x;
    if (state_r == ST_PA) begin
      in_raddr = xb;
    end else begin
      in_raddr = (job_r.op == OP_PARTNER) ? xa : y;
    end

    unique case (state_r)
      ST_IDLE: begin
        q_pop      = ~q_empty;
        second_nxt = 1'b0;
      end
      ST_SIMPLE: begin
        res_nxt.valid  = 1'b1;
        res_nxt.last   = 1'b1;
        res_nxt.status = (job_r.op == OP_BADID);
        res_nxt.edge_total = (job_r.op == OP_COUNT) ? cnt_r : 13'd0;
      end
      ST_UPD: begin
        if (cur != v_new) begin
          out_we  = 1'b1;
          in_we   = 1'b1;
          cnt_nxt = v_new ? cnt_r + 13'd1 : cnt_r - 13'd1;
        end
        v_nxt      = v_new;
        second_nxt = 1'b1;
        if (directed || second_r) begin
          res_nxt.valid = 1'b1;
          res_nxt.last  = 1'b1;
        end
      end
      ST_QRY: begin
        res_nxt.valid      = 1'b1;
        res_nxt.last       = 1'b1;
        res_nxt.edge_value = orow[xb];
      end
      ST_PA: begin
        sa_nxt = (directed && (job_r.sub == KIND_ISP || job_r.sub == KIND_ITP)) ?
                 irow : orow;
      end
      ST_PB: begin
        if (directed && (job_r.sub == KIND_OTP || job_r.sub == KIND_ISP)) begin
          mask_nxt = sa_r & irow;
        end else begin
          mask_nxt = sa_r & orow;
        end
        idx_nxt  = '0;
        have_nxt = 1'b0;
      end
      ST_SCAN: begin
        // a found partner is held back one hit so the final one can carry last
        if (mask_r[0]) begin
          if (have_r) begin
            res_nxt.valid         = 1'b1;
            res_nxt.partner_id    = pend_r;
            res_nxt.partner_valid = 1'b1;
          end
          pend_nxt = 7'({1'b0, idx_r} + (AW + 1)'(1));
          have_nxt = 1'b1;
        end
        mask_nxt = mask_r >> 1;
        idx_nxt  = idx_r + AW'(1);
      end
      ST_FLUSH: begin
        res_nxt.valid         = 1'b1;
        res_nxt.last          = 1'b1;
        res_nxt.partner_valid = have_r;
        res_nxt.partner_id    = have_r ? pend_r : 7'd0;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    second_r <= second_nxt;
    v_r      <= v_nxt;
    sa_r     <= sa_nxt;
    mask_r   <= mask_nxt;
    idx_r    <= idx_nxt;
    have_r   <= have_nxt;
    pend_r   <= pend_nxt;
  end

  assign res = res_r;

endmodule

FILE: sv/adjacency_bit_matrix_store_core.sv
// top level of the adjacency bit-matrix graph store
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------------
//  input    | start / busy     | in_cmd, in_from_actor, in_to_actor, in_partner_kind
//  result   | out_valid strobe | out_status, out_edge_value, out_edge_total,
//           |                  | out_partner_id, out_partner_valid, out_last
//  config   | cfg_we           | cfg_index, cfg_wdata
//
// edge count, unknown command and bad id: popped in ST_IDLE, answered from ST_SIMPLE
// toggle/add/delete: ST_RD1 then ST_UPD, one memory read-modify-write per direction
// common partners: ST_RD1, ST_PA, ST_PB, then ST_SCAN tests one column of the bit row per cycle
// a two-item queue takes items while the sequencer works; busy is high only when it is full
// reset clears row valid bits at once, so no clearing pass is needed
// results are strobed for one cycle and cannot be held off
module adjacency_bit_matrix_store_core #(
  parameter int unsigned MAX_ACTORS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [6:0]  in_from_actor,
  input  logic [6:0]  in_to_actor,
  input  logic [1:0]  in_partner_kind,
  output logic        out_valid,
  output logic        out_status,
  output logic        out_edge_value,
  output logic [12:0] out_edge_total,
  output logic [6:0]  out_partner_id,
  output logic        out_partner_valid,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);
  import abms_pkg::*;

  job_t push_job, head_job;
  res_t res;
  logic q_push, q_pop, q_full, q_empty, directed;

  abms_front #(.MAX_ACTORS(MAX_ACTORS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_cmd          (in_cmd),
    .in_from_actor   (in_from_actor),
    .in_to_actor     (in_to_actor),
    .in_partner_kind (in_partner_kind),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .q_full          (q_full),
    .busy            (busy),
    .q_push          (q_push),
    .q_job           (push_job),
    .directed        (directed)
  );

  abms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  abms_back #(.MAX_ACTORS(MAX_ACTORS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .directed (directed),
    .q_empty  (q_empty),
    .q_head   (head_job),
    .q_pop    (q_pop),
    .res      (res)
  );

  assign out_valid         = res.valid;
  assign out_status        = res.status;
  assign out_edge_value    = res.edge_value;
  assign out_edge_total    = res.edge_total;
  assign out_partner_id    = res.partner_id;
  assign out_partner_valid = res.partner_valid;
  assign out_last          = res.last;

endmodule

FILE: sv/abms_checker.sv
// port-level checks for the adjacency bit-matrix store, bound to the top level
module abms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_status,
  input logic        out_edge_value,
  input logic [12:0] out_edge_total,
  input logic [6:0]  out_partner_id,
  input logic        out_partner_valid,
  input logic        out_last
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // a bad id answer is a single bare item
  a_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |->
      out_last && !out_partner_valid && !out_edge_value && out_edge_total == 13'd0)
    else $error("bad id result carries payload");

  // only partner lists give items that are not final
  a_nonfinal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_partner_valid && !out_status)
    else $error("non-final item that is not a partner");

  // a partner reported as absent has id zero
  a_no_partner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_partner_valid |-> out_partner_id == 7'd0)
    else $error("partner id without a partner");

endmodule

bind adjacency_bit_matrix_store_core abms_checker u_abms_checker (.*);

FILE: verif/tb_adjacency_bit_matrix_store_core.sv
`timescale 1ns / 1ps
// self-checking testbench for the adjacency bit-matrix graph store core
module tb_adjacency_bit_matrix_store_core;
  import abms_pkg::*;

  // command codes the block must ignore
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES = 10;
  localparam int HOT_ACTORS    = 8;
  localparam int MAX_REPORTS   = 200;

  typedef struct packed {
    logic        status;
    logic        edge_value;
    logic [12:0] edge_total;
    logic [6:0]  partner_id;
    logic        partner_valid;
    logic        last;
  } graph_res_t;

  localparam graph_res_t RES_DONE = '{status: 1'b0, edge_value: 1'b0, edge_total: 13'd0,
                                      partner_id: 7'd0, partner_valid: 1'b0, last: 1'b1};
  localparam graph_res_t RES_BADID = '{status: 1'b1, edge_value: 1'b0, edge_total: 13'd0,
                                       partner_id: 7'd0, partner_valid: 1'b0, last: 1'b1};

  typedef enum logic [1:0] {CHK_PRED, CHK_DONE, CHK_BADID} chk_t;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_t;

  // config rows carry the mode in from_id[0] and the actor count in to_id
  typedef struct packed {
    row_t       kind;
    logic [2:0] cmd;
    logic [6:0] from_id;
    logic [6:0] to_id;
    logic [1:0] pkind;
    chk_t       chk;
  } stim_row_t;

  localparam int NUM_ROWS = 30;
  localparam stim_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    '{ROW_ITEM, CMD_COUNT,    7'd0,   7'd0,   KIND_OSP, CHK_DONE},
    '{ROW_ITEM, CMD_QUERY,    7'd1,   7'd64,  KIND_OSP, CHK_DONE},
    '{ROW_ITEM, CMD_PARTNER,  7'd1,   7'd64,  KIND_OSP, CHK_DONE},
    '{ROW_ITEM, CMD_ADD,      7'd1,   7'd64,  KIND_OSP, CHK_DONE},
    '{ROW_ITEM, CMD_ADD,      7'd64,  7'd1,   KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_ADD,      7'd64,  7'd64,  KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_TOGGLE,   7'd1,   7'd1,   KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_QUERY,    7'd1,   7'd64,  KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_COUNT,    7'd127, 7'd0,   KIND_ITP, CHK_PRED},
    '{ROW_ITEM, CMD_PARTNER,  7'd64,  7'd1,   KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_PARTNER,  7'd1,   7'd64,  KIND_OTP, CHK_PRED},
    '{ROW_ITEM, CMD_PARTNER,  7'd1,   7'd64,  KIND_ISP, CHK_PRED},
    '{ROW_ITEM, CMD_PARTNER,  7'd1,   7'd64,  KIND_ITP, CHK_PRED},
    '{ROW_ITEM, CMD_QUERY,    7'd0,   7'd5,   KIND_OSP, CHK_BADID},
    '{ROW_ITEM, CMD_ADD,      7'd65,  7'd1,   KIND_OSP, CHK_BADID},
    '{ROW_ITEM, CMD_TOGGLE,   7'd3,   7'd127, KIND_OSP, CHK_BADID},
    '{ROW_ITEM, CMD_PARTNER,  7'd0,   7'd0,   KIND_ITP, CHK_BADID},
    '{ROW_ITEM, CMD_SPARE_LO, 7'd127, 7'd127, KIND_ITP, CHK_DONE},
    '{ROW_ITEM, CMD_SPARE_HI, 7'd1,   7'd1,   KIND_OSP, CHK_DONE},
    '{ROW_ITEM, CMD_DELETE,   7'd1,   7'd64,  KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_TOGGLE,   7'd1,   7'd64,  KIND_OSP, CHK_PRED},
    // switch to undirected with edges already stored
    '{ROW_CFG,  CMD_TOGGLE,   7'd0,   7'd64,  KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_PARTNER,  7'd1,   7'd64,  KIND_ISP, CHK_PRED},
    '{ROW_ITEM, CMD_TOGGLE,   7'd2,   7'd3,   KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_TOGGLE,   7'd64,  7'd1,   KIND_OSP, CHK_PRED},
    // single actor: edges on higher ids still count and still show as partners
    '{ROW_CFG,  CMD_TOGGLE,   7'd1,   7'd1,   KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_QUERY,    7'd1,   7'd2,   KIND_OSP, CHK_BADID},
    '{ROW_ITEM, CMD_COUNT,    7'd0,   7'd0,   KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_PARTNER,  7'd1,   7'd1,   KIND_OSP, CHK_PRED},
    '{ROW_ITEM, CMD_QUERY,    7'd1,   7'd1,   KIND_OSP, CHK_PRED}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = CMD_TOGGLE;
  logic [6:0]  in_from_actor = 7'd0;
  logic [6:0]  in_to_actor = 7'd0;
  logic [1:0]  in_partner_kind = KIND_OSP;
  logic        out_valid;
  logic        out_status;
  logic        out_edge_value;
  logic [12:0] out_edge_total;
  logic [6:0]  out_partner_id;
  logic        out_partner_valid;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_DIRECTED;
  logic [6:0]  cfg_wdata = 7'd0;

  // predictor copy of the graph and its settings
  logic [63:0] out_rows [64];
  logic [63:0] in_rows [64];
  logic [12:0] edge_cnt = 13'd0;
  logic        dir_mode = 1'b1;
  logic [6:0]  act_cnt = ACTORS_RST;

  graph_res_t  pred_res [64];
  graph_res_t  pending_q [$];
  graph_res_t  got_exp;
  bit          idle_on = 1'b1;
  int          err_cnt = 0;

  always #4 clk = ~clk;

  adjacency_bit_matrix_store_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_from_actor    (in_from_actor),
    .in_to_actor      (in_to_actor),
    .in_partner_kind  (in_partner_kind),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_edge_value   (out_edge_value),
    .out_edge_total   (out_edge_total),
    .out_partner_id   (out_partner_id),
    .out_partner_valid(out_partner_valid),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  function automatic logic [6:0] actor_limit();
    return (act_cnt > 7'd64) ? 7'd64 : act_cnt;
  endfunction

  function automatic void write_edge(input logic [5:0] src, input logic [5:0] dst,
                                     input logic val);
    if (out_rows[src][dst] != val) begin
      out_rows[src][dst] = val;
      in_rows[dst][src]  = val;
      edge_cnt = val ? edge_cnt + 13'd1 : edge_cnt - 13'd1;
    end
  endfunction

  // works out the results of one command and applies its effect on the graph
  function automatic int graph_command(input logic [2:0] c, input logic [6:0] f,
                                       input logic [6:0] t, input logic [1:0] k);
    logic [6:0]  lim;
    logic [5:0]  a;
    logic [5:0]  b;
    logic        val;
    logic [63:0] set_a;
    logic [63:0] set_b;
    logic [63:0] both;
    int          n;
    lim = actor_limit();
    n = 1;
    pred_res[0] = RES_DONE;
    if (c == CMD_COUNT) begin
      pred_res[0].edge_total = edge_cnt;
    end else if (c == CMD_SPARE_LO || c == CMD_SPARE_HI) begin
      pred_res[0] = RES_DONE;
    end else if (f < 7'd1 || f > lim || t < 7'd1 || t > lim) begin
      pred_res[0] = RES_BADID;
    end else begin
      a = 6'(f - 7'd1);
      b = 6'(t - 7'd1);
      case (c)
        CMD_TOGGLE, CMD_ADD, CMD_DELETE: begin
          val = (c == CMD_TOGGLE) ? ~out_rows[a][b] : (c == CMD_ADD);
          write_edge(a, b, val);
          if (!dir_mode) write_edge(b, a, val);
        end
        CMD_QUERY: begin
          pred_res[0].edge_value = out_rows[a][b];
        end
        default: begin
          // undirected reads take out-rows for every set
          set_a = (k == KIND_OSP || k == KIND_OTP || !dir_mode) ? out_rows[a] : in_rows[a];
          set_b = (k == KIND_OSP || k == KIND_ITP || !dir_mode) ? out_rows[b] : in_rows[b];
          both = set_a & set_b;
          n = 0;
          for (int i = 0; i < 64; i++) begin
            if (both[i]) begin
              pred_res[n] = '0;
              pred_res[n].partner_id = 7'(i + 1);
              pred_res[n].partner_valid = 1'b1;
              n++;
            end
          end
          if (n == 0) n = 1;
          else pred_res[n-1].last = 1'b1;
        end
      endcase
    end
    return n;
  endfunction

  task automatic send_item(input logic [2:0] c, input logic [6:0] f, input logic [6:0] t,
                           input logic [1:0] k, input chk_t chk);
    int n;
    while (idle_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_cmd          <= c;
    in_from_actor   <= f;
    in_to_actor     <= t;
    in_partner_kind <= k;
    do @(posedge clk); while (busy);
    n = graph_command(c, f, t, k);
    case (chk)
      CHK_DONE:  pending_q.push_back(RES_DONE);
      CHK_BADID: pending_q.push_back(RES_BADID);
      default:   for (int i = 0; i < n; i++) pending_q.push_back(pred_res[i]);
    endcase
  endtask

  // hold off new items until every expected result is back and the block is quiet
  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic dir, input logic [6:0] cnt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIRECTED;
    cfg_wdata <= {6'd0, dir};
    @(posedge clk);
    cfg_index <= CFG_ACTORS;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dir_mode = dir;
    act_cnt  = cnt;
  endtask

  // mostly ids from a small hot set so that partner lists get long
  function automatic logic [6:0] pick_id();
    int r;
    int lim;
    lim = int'(actor_limit());
    r = $urandom_range(99);
    if (r < 8) return 7'($urandom_range(127));
    if (r < 70) return 7'($urandom_range(1, (lim < HOT_ACTORS) ? lim : HOT_ACTORS));
    return 7'($urandom_range(1, lim));
  endfunction

  task automatic random_item();
    logic [2:0] c;
    int         r;
    r = $urandom_range(99);
    if (r < 20)      c = CMD_ADD;
    else if (r < 32) c = CMD_TOGGLE;
    else if (r < 42) c = CMD_DELETE;
    else if (r < 56) c = CMD_QUERY;
    else if (r < 61) c = CMD_COUNT;
    else if (r < 95) c = CMD_PARTNER;
    else             c = (r < 97) ? CMD_SPARE_LO : CMD_SPARE_HI;
    send_item(c, pick_id(), pick_id(), 2'($urandom_range(3)), CHK_PRED);
  endtask

  task automatic run_phase(input logic dir, input logic [6:0] cnt, input int items,
                           input bit gaps);
    drain();
    set_config(dir, cnt);
    idle_on = gaps;
    repeat (items) random_item();
  endtask

  function automatic void check_field(input string name, input logic [12:0] want,
                                      input logic [12:0] got);
    if (got !== want) begin
      err_cnt++;
      // keep the log readable when the block is badly off
      if (err_cnt <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $error("result with no item outstanding");
      end else begin
        got_exp = pending_q.pop_front();
        check_field("status", 13'(got_exp.status), 13'(out_status));
        check_field("edge_value", 13'(got_exp.edge_value), 13'(out_edge_value));
        check_field("edge_total", got_exp.edge_total, out_edge_total);
        check_field("partner_id", 13'(got_exp.partner_id), 13'(out_partner_id));
        check_field("partner_valid", 13'(got_exp.partner_valid), 13'(out_partner_valid));
        check_field("last", 13'(got_exp.last), 13'(out_last));
      end
    end
  end

  initial begin
    for (int i = 0; i < 64; i++) begin
      out_rows[i] = '0;
      in_rows[i]  = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        drain();
        set_config(DIRECTED_ROWS[i].from_id[0], DIRECTED_ROWS[i].to_id);
      end else begin
        send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].from_id, DIRECTED_ROWS[i].to_id,
                  DIRECTED_ROWS[i].pkind, DIRECTED_ROWS[i].chk);
      end
    end

    run_phase(1'b1, 7'd64, 50, 1'b1);
    run_phase(1'b0, 7'd64, 50, 1'b1);
    run_phase(1'b1, 7'd5,  50, 1'b0);
    run_phase(1'b0, 7'd3,  40, 1'b1);
    run_phase(1'b1, 7'd64, 70, 1'b1);
    drain();

    if (err_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
sv/abms_pkg.sv
sv/abms_front.sv
sv/abms_queue.sv
sv/abms_back.sv
sv/adjacency_bit_matrix_store_core.sv
sv/abms_checker.sv
verif/tb_adjacency_bit_matrix_store_core.sv
